>>> hdl/assert_macros.svh
// Assertion macros shared by the monitor RTL.
// Expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define MKFD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Trigger this cycle implies the property on the next cycle.
`define MKFD_ASSERT_NEXT(label, trig, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) \
		(trig) |=> (prop)) else $error(msg);

`endif

>>> hdl/mkfd_pkg.sv
// Package for the (m,k)-firm distance monitor: widths, register indexes,
// reset values, sequencer states and control structs. No dependencies.
package mkfd_pkg;

	localparam int CNT_W = 6;

	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic             cfg_idx_t;

	localparam cfg_idx_t REG_REQUIRED_MET  = 1'b0;
	localparam cfg_idx_t REG_WINDOW_LENGTH = 1'b1;

	localparam cnt_t REQ_MET_RESET = 6'd1;
	localparam cnt_t WINDOW_RESET  = 6'd32;

	typedef enum logic [1:0] {
		SCAN_IDLE,
		SCAN_RUN,
		SCAN_DONE
	} scan_state_t;

	typedef struct packed {
		logic start;     // item transfer this cycle
		logic skip;      // no scan needed, distance is zero
		logic out_free;  // output register can load this cycle
	} scan_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} scan_sts_t;

endpackage

>>> hdl/mkfd_scan_unit.sv
// Iterative backward scan over the history ring: one slot per cycle,
// counting met jobs until the m-th is found or k slots are checked. Depends on mkfd_pkg.
`include "assert_macros.svh"

module mkfd_scan_unit import mkfd_pkg::*; #(
	parameter int PTR_W = 5
) (
	input  logic             clk,
	input  logic             arst_n,
	input  scan_ctl_t        ctl,
	input  cnt_t             m,
	input  cnt_t             k,
	input  logic [PTR_W-1:0] start_ptr,
	input  logic             hist_bit,
	output logic [PTR_W-1:0] ptr,
	output cnt_t             distance,
	output scan_sts_t        sts
);

	scan_state_t      state_q, state_n;
	logic [PTR_W-1:0] ptr_q;
	cnt_t             step_q;
	cnt_t             ctr_q;
	cnt_t             m_q;
	cnt_t             k_q;
	cnt_t             dist_q;
	cnt_t             ctr_n;
	logic             hit;
	logic             last;

	assign ctr_n = ctr_q + cnt_t'(hist_bit);
	assign hit   = (ctr_n == m_q);
	assign last  = (step_q == k_q - cnt_t'(1));

	always_comb begin
		state_n = state_q;
		case (state_q)
			SCAN_IDLE: begin
				if (ctl.start) begin
					state_n = ctl.skip ? SCAN_DONE : SCAN_RUN;
				end
			end
			SCAN_RUN: begin
				if (hit || last) begin
					state_n = SCAN_DONE;
				end
			end
			SCAN_DONE: begin
				if (ctl.out_free) begin
					state_n = SCAN_IDLE;
				end
			end
			default: state_n = SCAN_IDLE;
		endcase
	end

	always_comb begin
		sts.busy = (state_q != SCAN_IDLE);
		sts.done = (state_q == SCAN_DONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SCAN_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			SCAN_IDLE: begin
				if (ctl.start) begin
					ptr_q  <= start_ptr;
					step_q <= '0;
					ctr_q  <= '0;
					m_q    <= m;
					k_q    <= k;
					dist_q <= '0;
				end
			end
			SCAN_RUN: begin
				ctr_q <= ctr_n;
				if (hit) begin
					dist_q <= k_q - step_q;
				end else if (!last) begin
					step_q <= step_q + cnt_t'(1);
					// wrap from slot 0 to the top slot (k - 1) of the window
					ptr_q  <= (ptr_q == '0) ? PTR_W'(k_q - cnt_t'(1)) : ptr_q - PTR_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	assign ptr      = ptr_q;
	assign distance = dist_q;

	`MKFD_ASSERT(a_step_in_window, (state_q == SCAN_RUN) |-> (step_q < k_q), "scan step past window")
	`MKFD_ASSERT(a_start_when_idle, ctl.start |-> (state_q == SCAN_IDLE), "start while busy")
	`MKFD_ASSERT_NEXT(a_done_holds, (state_q == SCAN_DONE) && !ctl.out_free, state_q == SCAN_DONE, "done dropped")

endmodule

>>> hdl/mk_firm_distance_monitor_unit.sv
// Top level of the (m,k)-firm distance monitor: config registers, history
// ring, output register. Depends on mkfd_pkg and mkfd_scan_unit.
//
// Usage:
//   cfg_we/cfg_index/cfg_data write required_met (index 0) or window_length
//   (index 1). A window_length write restarts the history to all met. Write
//   only while the block is idle.
//   Input channel: outcome with in_valid/in_stall; a transfer happens when
//   in_valid is high and in_stall is low. in_stall is high while an item is
//   being processed.
//   Output channel: distance, met_count, violated, config_error with
//   out_valid/out_stall, held in an output register.
// Sequence:
//   The transfer edge writes the history slot. The scan unit then checks one
//   history slot per cycle, newest first, for up to k slots (k = effective
//   window), and then its done state loads the output register. When no scan
//   is needed the scan unit goes straight to done. The next item is taken
//   once the result has loaded, so a new item is never accepted while one
//   is still being processed.
//   If out_stall holds a previous result, the finished scan waits in its done
//   state until the output register frees.
// Reset: required_met 1, window_length 32, history all met, no result pending.
`include "assert_macros.svh"

module mk_firm_distance_monitor_unit import mkfd_pkg::*; #(
	parameter int HISTORY_DEPTH = 32
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cfg_we,
	input  cfg_idx_t cfg_index,
	input  cnt_t     cfg_data,
	input  logic     in_valid,
	output logic     in_stall,
	input  logic     outcome,
	output logic     out_valid,
	input  logic     out_stall,
	output cnt_t     distance,
	output cnt_t     met_count,
	output logic     violated,
	output logic     config_error
);

	localparam int PTR_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam logic [CNT_W:0] DEPTH_X = (CNT_W+1)'(HISTORY_DEPTH);

	// window_length 0 acts as 1, values above the ring size clamp to it
	function automatic cnt_t eff_window(input cnt_t wl);
		if (wl == '0) begin
			eff_window = cnt_t'(1);
		end else if ({1'b0, wl} > DEPTH_X) begin
			eff_window = DEPTH_X[CNT_W-1:0];
		end else begin
			eff_window = wl;
		end
	endfunction

	cnt_t                     req_met_q;
	cnt_t                     window_q;
	logic [HISTORY_DEPTH-1:0] hist_q;
	logic [PTR_W-1:0]         wp_q;
	cnt_t                     ones_q;
	logic                     out_valid_q;
	cnt_t                     distance_q;
	cnt_t                     met_count_q;
	logic                     violated_q;
	logic                     cfg_err_q;

	cnt_t             k;
	logic [PTR_W-1:0] pos;
	logic [PTR_W-1:0] scan_ptr;
	cnt_t             scan_dist;
	logic             accept;
	logic             out_free;
	logic             cfg_err;
	scan_ctl_t        scan_ctl;
	scan_sts_t        scan_sts;

	assign k        = eff_window(window_q);
	assign pos      = ((CNT_W+1)'(wp_q) >= (CNT_W+1)'(k)) ? '0 : wp_q;
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign cfg_err  = (req_met_q > k);
	assign in_stall = scan_sts.busy;

	assign scan_ctl.start    = accept;
	assign scan_ctl.skip     = cfg_err || (req_met_q == '0);
	assign scan_ctl.out_free = out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_met_q <= REQ_MET_RESET;
			window_q  <= WINDOW_RESET;
			hist_q    <= '1;
			wp_q      <= '0;
			ones_q    <= eff_window(WINDOW_RESET);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_REQUIRED_MET: begin
					req_met_q <= cfg_data;
				end
				REG_WINDOW_LENGTH: begin
					window_q <= cfg_data;
					hist_q   <= '1;
					wp_q     <= '0;
					ones_q   <= eff_window(cfg_data);
				end
				default: begin
				end
			endcase
		end else if (accept) begin
			ones_q      <= ones_q - cnt_t'(hist_q[pos]) + cnt_t'(outcome);
			hist_q[pos] <= outcome;
			wp_q        <= ((CNT_W+1)'(pos) + (CNT_W+1)'(1) >= (CNT_W+1)'(k))
			               ? '0 : pos + PTR_W'(1);
		end
	end

	mkfd_scan_unit #(
		.PTR_W (PTR_W)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (scan_ctl),
		.m         (req_met_q),
		.k         (k),
		.start_ptr (pos),
		.hist_bit  (hist_q[scan_ptr]),
		.ptr       (scan_ptr),
		.distance  (scan_dist),
		.sts       (scan_sts)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (scan_sts.done && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (scan_sts.done && out_free) begin
			distance_q  <= scan_dist;
			met_count_q <= ones_q;
			violated_q  <= (ones_q < req_met_q);
			cfg_err_q   <= cfg_err;
		end
	end

	assign out_valid    = out_valid_q;
	assign distance     = distance_q;
	assign met_count    = met_count_q;
	assign violated     = violated_q;
	assign config_error = cfg_err_q;

	`MKFD_ASSERT_NEXT(a_busy_after_transfer, accept, in_stall, "not busy after input transfer")
	`MKFD_ASSERT(a_err_zero_dist, (out_valid_q && cfg_err_q) |-> (distance_q == '0), "error with distance")
	`MKFD_ASSERT(a_found_not_violated, (out_valid_q && (distance_q != '0)) |-> !violated_q, "found but violated")

endmodule

>>> tb/tb_mk_firm_distance_monitor_unit.sv
// Self-checking bench for mk_firm_distance_monitor_unit: directed and random job
// outcomes checked against an in-bench (m,k)-firm distance predictor.
// Depends on mkfd_pkg and the monitor RTL.
module tb_mk_firm_distance_monitor_unit;
	import mkfd_pkg::*;

	localparam int DEPTH      = 32;
	localparam int N_RANDOM   = 700;
	localparam int MAX_CYCLES = 400000;

	typedef struct packed {
		cnt_t distance;
		cnt_t met_count;
		logic violated;
		logic config_error;
	} firm_status_t;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     cfg_we = 1'b0;
	cfg_idx_t cfg_index = REG_REQUIRED_MET;
	cnt_t     cfg_data = '0;
	logic     in_valid = 1'b0;
	logic     in_stall;
	logic     outcome = 1'b0;
	logic     out_valid;
	logic     out_stall = 1'b0;
	cnt_t     distance;
	cnt_t     met_count;
	logic     violated;
	logic     config_error;

	// predictor state
	logic [DEPTH-1:0] history;
	int unsigned      wr_slot;
	int unsigned      met_in_window;
	cnt_t             req_met = REQ_MET_RESET;
	cnt_t             win_len = WINDOW_RESET;

	firm_status_t status_q[$];
	logic         outcome_q[$];

	int unsigned mismatches = 0;
	int unsigned fed = 0;
	int unsigned cycles = 0;
	int unsigned in_gap = 0;
	int unsigned out_hold = 0;
	logic        in_quiet = 1'b0;
	logic        out_quiet = 1'b0;
	logic        in_taken = 1'b0;
	logic        out_taken = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	mk_firm_distance_monitor_unit #(.HISTORY_DEPTH(DEPTH)) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.outcome      (outcome),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.distance     (distance),
		.met_count    (met_count),
		.violated     (violated),
		.config_error (config_error)
	);

	function automatic int unsigned window_eff();
		if (win_len == 0) return 1;
		if (win_len > DEPTH) return DEPTH;
		return win_len;
	endfunction

	function automatic void restart_history();
		history = '1;
		wr_slot = 0;
		met_in_window = window_eff();
	endfunction

	// Logs one outcome into the ring and scans newest-first for the m-th met job.
	function automatic firm_status_t record_outcome(logic met);
		int unsigned  k, m, slot, p, i, hits, span;
		logic         found, cfg_err;
		firm_status_t r;
		k = window_eff();
		m = req_met;
		slot = (wr_slot >= k) ? 0 : wr_slot;
		met_in_window = met_in_window - history[slot] + met;
		history[slot] = met;
		wr_slot = (slot + 1 >= k) ? 0 : slot + 1;
		cfg_err = (m > k);
		span = 0;
		if (!cfg_err && m != 0) begin
			p = (wr_slot == 0) ? k - 1 : wr_slot - 1;
			hits = 0;
			found = 1'b0;
			for (i = 0; i < k; i++) begin
				if (history[p]) hits++;
				if (hits == m) begin
					found = 1'b1;
					break;
				end
				p = (p == 0) ? k - 1 : p - 1;
			end
			if (found) span = k - i;
		end
		r.distance = cnt_t'(span);
		r.met_count = cnt_t'(met_in_window);
		r.violated = (met_in_window < m);
		r.config_error = cfg_err;
		return r;
	endfunction

	// monitor: check result transfers, then predict for input transfers
	always @(posedge clk) begin
		firm_status_t got, want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got = '{distance, met_count, violated, config_error};
				if (status_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: dist %0d met %0d viol %b cerr %b",
							got.distance, got.met_count, got.violated, got.config_error);
				end else begin
					want = status_q.pop_front();
					if (got.distance !== want.distance || got.met_count !== want.met_count ||
						got.violated !== want.violated ||
						got.config_error !== want.config_error) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: exp dist %0d met %0d viol %b cerr %b, %s %0d %0d %b %b",
								want.distance, want.met_count, want.violated, want.config_error,
								"got", got.distance, got.met_count, got.violated,
								got.config_error);
					end
				end
			end
			if (in_valid && !in_stall)
				status_q.push_back(record_outcome(outcome));
		end
		in_taken <= arst_n && in_valid && !in_stall;
		out_taken <= arst_n && out_valid && !out_stall;
	end

	// driver: one outcome per transfer, random gap after each (none when in_quiet)
	always @(negedge clk) begin
		logic v;
		v = in_valid;
		if (in_taken) v = 1'b0;
		if (arst_n && !v) begin
			if (in_gap > 0) begin
				in_gap--;
			end else if (outcome_q.size() > 0) begin
				outcome <= outcome_q.pop_front();
				v = 1'b1;
				in_gap = in_quiet ? 0 : $urandom_range(0, 11);
			end
		end
		in_valid <= v;
	end

	// result side: random stall after each transfer (none when out_quiet)
	always @(negedge clk) begin
		if (out_taken) out_hold = out_quiet ? 0 : $urandom_range(0, 11);
		else if (out_hold > 0) out_hold--;
		out_stall <= (out_hold > 0);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= MAX_CYCLES) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic write_reg(cfg_idx_t idx, cnt_t val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_REQUIRED_MET) begin
			req_met = val;
		end else begin
			win_len = val;
			restart_history();
		end
	endtask

	task automatic feed(int n, int met_pct);
		repeat (n) begin
			outcome_q.push_back(logic'($urandom_range(0, 99) < met_pct));
			fed++;
		end
	endtask

	// sender holds off until every pending result has come back
	task automatic settle();
		while (outcome_q.size() != 0 || in_valid || status_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		int unsigned sel, keff, n;
		restart_history();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset defaults: m=1, k=32
		feed(3, 0);
		feed(2, 100);
		settle();
		// required zero
		write_reg(REG_REQUIRED_MET, 6'd0);
		feed(1, 0);
		feed(1, 100);
		settle();
		// required above window
		write_reg(REG_WINDOW_LENGTH, 6'd2);
		write_reg(REG_REQUIRED_MET, 6'd3);
		feed(1, 100);
		feed(1, 0);
		settle();
		// window of zero acts as one
		write_reg(REG_WINDOW_LENGTH, 6'd0);
		write_reg(REG_REQUIRED_MET, 6'd1);
		feed(1, 0);
		feed(2, 100);
		settle();
		// window above depth clamps to depth, m = k
		write_reg(REG_WINDOW_LENGTH, 6'd63);
		write_reg(REG_REQUIRED_MET, 6'd32);
		feed(1, 100);
		feed(1, 0);
		feed(1, 100);
		settle();
		write_reg(REG_WINDOW_LENGTH, 6'd33);
		write_reg(REG_REQUIRED_MET, 6'd63);
		feed(1, 0);
		settle();
		write_reg(REG_WINDOW_LENGTH, 6'd1);
		write_reg(REG_REQUIRED_MET, 6'd1);
		feed(1, 100);
		feed(1, 0);
		settle();
		// required rewrite keeps the history
		write_reg(REG_WINDOW_LENGTH, 6'd32);
		write_reg(REG_REQUIRED_MET, 6'd32);
		feed(1, 0);
		settle();
		write_reg(REG_REQUIRED_MET, 6'd1);
		feed(1, 100);
		settle();
		write_reg(REG_WINDOW_LENGTH, 6'd5);
		write_reg(REG_REQUIRED_MET, 6'd5);
		feed(2, 0);
		feed(3, 100);
		settle();

		while (fed < 25 + N_RANDOM) begin
			if ($urandom_range(0, 9) < 7) begin
				sel = $urandom_range(0, 15);
				if (sel == 0) write_reg(REG_WINDOW_LENGTH, 6'd0);
				else if (sel == 1) write_reg(REG_WINDOW_LENGTH, cnt_t'($urandom_range(33, 63)));
				else write_reg(REG_WINDOW_LENGTH, cnt_t'($urandom_range(1, DEPTH)));
			end
			keff = window_eff();
			sel = $urandom_range(0, 15);
			if (sel == 0) write_reg(REG_REQUIRED_MET, 6'd0);
			else if (sel == 1) write_reg(REG_REQUIRED_MET, cnt_t'($urandom_range(keff + 1, 63)));
			else write_reg(REG_REQUIRED_MET, cnt_t'($urandom_range(1, keff)));
			in_quiet = ($urandom_range(0, 3) == 0);
			out_quiet = ($urandom_range(0, 3) == 0);
			n = $urandom_range(10, 50);
			feed(n, $urandom_range(40, 100));
			settle();
		end

		repeat (40) @(posedge clk);
		if (status_q.size() != 0) mismatches++;
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

>>> mk_firm_distance_monitor_unit.f
+incdir+hdl
hdl/mkfd_pkg.sv
hdl/mkfd_scan_unit.sv
hdl/mk_firm_distance_monitor_unit.sv
tb/tb_mk_firm_distance_monitor_unit.sv
